/* design/ptfig_pkg.sv */
package ptfig_pkg;

  localparam int MAX_CORNERS = 16;
  localparam int NUM_LAYERS  = 5;
  localparam int LAYER_BASE  = 8;
  localparam int LAYER_WORDS = 6;
  localparam int MASK_ADDR   = LAYER_BASE + LAYER_WORDS * NUM_LAYERS;
  localparam int STORE_DEPTH = MASK_ADDR + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_CORNERS + 1);
  localparam int LAYER_W     = 3;
  localparam int STEP_W      = 4;
  localparam int FRAC        = 16;
  localparam int PROD_W      = 65;
  localparam int FL_W        = PROD_W - FRAC;
  localparam int ACC_W       = 51;
  localparam int SAT_W       = 52;

  localparam int IN_TDATA_W  = 168;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 144;

  // word offsets inside the store
  localparam int W_AXIS_U = 0;
  localparam int W_AXIS_V = 3;
  localparam int W_OFF_U  = 6;
  localparam int W_OFF_V  = 7;
  localparam int LW_PAN_U = 0;
  localparam int LW_PAN_V = 1;
  localparam int LW_SCL_U = 2;
  localparam int LW_SCL_V = 3;
  localparam int LW_OFS_U = 4;
  localparam int LW_OFS_V = 5;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_FAN    = 2'd2;

  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  // projection sequence
  localparam logic [STEP_W-1:0] P_MX_U  = 4'd0;
  localparam logic [STEP_W-1:0] P_MY_U  = 4'd1;
  localparam logic [STEP_W-1:0] P_MZ_U  = 4'd2;
  localparam logic [STEP_W-1:0] P_ACC_U = 4'd3;
  localparam logic [STEP_W-1:0] P_OFF_U = 4'd4;
  localparam logic [STEP_W-1:0] P_MX_V  = 4'd5;
  localparam logic [STEP_W-1:0] P_MY_V  = 4'd6;
  localparam logic [STEP_W-1:0] P_MZ_V  = 4'd7;
  localparam logic [STEP_W-1:0] P_ACC_V = 4'd8;
  localparam logic [STEP_W-1:0] P_OFF_V = 4'd9;

  // per-layer sequence
  localparam logic [STEP_W-1:0] L_PAN_U = 4'd0;
  localparam logic [STEP_W-1:0] L_SCL_U = 4'd1;
  localparam logic [STEP_W-1:0] L_OFS_U = 4'd2;
  localparam logic [STEP_W-1:0] L_PAN_V = 4'd3;
  localparam logic [STEP_W-1:0] L_SCL_V = 4'd4;
  localparam logic [STEP_W-1:0] L_OFS_V = 4'd5;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sd2147483648);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_VERTEX,
    OP_FAN
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROJ,
    ST_LAYER,
    ST_FAN
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [ADDR_W-1:0]  addr;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [23:0]        first;
    logic [CNT_W-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [LAYER_W-1:0] layer;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [23:0]        corner_a;
    logic [23:0]        corner_b;
    logic [23:0]        corner_c;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               found;
    logic [LAYER_W-1:0] idx;
  } lsel_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] proj_addr(input logic [STEP_W-1:0] step);
    logic [ADDR_W-1:0] a;
    case (step)
      P_MX_U:  a = ADDR_W'(W_AXIS_U);
      P_MY_U:  a = ADDR_W'(W_AXIS_U + 1);
      P_MZ_U:  a = ADDR_W'(W_AXIS_U + 2);
      P_OFF_U: a = ADDR_W'(W_OFF_U);
      P_MX_V:  a = ADDR_W'(W_AXIS_V);
      P_MY_V:  a = ADDR_W'(W_AXIS_V + 1);
      P_MZ_V:  a = ADDR_W'(W_AXIS_V + 2);
      P_OFF_V: a = ADDR_W'(W_OFF_V);
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] layer_addr(input logic [LAYER_W-1:0] layer,
                                                   input logic [STEP_W-1:0]  step);
    logic [ADDR_W-1:0] w;
    case (step)
      L_PAN_U: w = ADDR_W'(LW_PAN_U);
      L_SCL_U: w = ADDR_W'(LW_SCL_U);
      L_OFS_U: w = ADDR_W'(LW_OFS_U);
      L_PAN_V: w = ADDR_W'(LW_PAN_V);
      L_SCL_V: w = ADDR_W'(LW_SCL_V);
      L_OFS_V: w = ADDR_W'(LW_OFS_V);
      default: w = '0;
    endcase
    return ADDR_W'(LAYER_BASE) + ADDR_W'(layer) * ADDR_W'(LAYER_WORDS) + w;
  endfunction

  // lowest enabled layer at or above 'from'
  function automatic lsel_t next_layer(input logic [NUM_LAYERS-1:0] mask,
                                       input logic [LAYER_W:0]      from);
    lsel_t r;
    r = '0;
    for (int i = NUM_LAYERS - 1; i >= 0; i--) begin
      if (mask[i] && ((LAYER_W + 1)'(i) >= from)) begin
        r.found = 1'b1;
        r.idx   = LAYER_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* design/ptfig_front.sv */
module ptfig_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // param_index, param_value, pos_x, pos_y, pos_z, first_vertex, corner_count, zero pad
  input  logic [ptfig_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // command
  input  logic [ptfig_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                                 cmd_valid_o,
  output ptfig_pkg::cmd_t                      cmd_o,
  input  logic                                 cmd_ready_i
);

  localparam int MIN_CORNERS = 3;

  logic [5:0]  param_index;
  logic [4:0]  corner_count;
  logic        keep;
  ptfig_pkg::cmd_t cmd_in;

  ptfig_pkg::cmd_t q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign param_index  = s_axis_tdata_i[5:0];
  assign corner_count = s_axis_tdata_i[162:158];

  always_comb begin
    cmd_in       = '0;
    cmd_in.addr  = ptfig_pkg::ADDR_W'(param_index);
    cmd_in.value = s_axis_tdata_i[37:6];
    cmd_in.pos_x = s_axis_tdata_i[69:38];
    cmd_in.pos_y = s_axis_tdata_i[101:70];
    cmd_in.pos_z = s_axis_tdata_i[133:102];
    cmd_in.first = s_axis_tdata_i[157:134];
    if (int'(corner_count) > ptfig_pkg::MAX_CORNERS) begin
      cmd_in.count = ptfig_pkg::CNT_W'(ptfig_pkg::MAX_CORNERS);
    end else begin
      cmd_in.count = ptfig_pkg::CNT_W'(corner_count);
    end
    keep = 1'b0;
    case (s_axis_tuser_i)
      ptfig_pkg::CMD_WRITE: begin
        cmd_in.op = ptfig_pkg::OP_WRITE;
        keep      = int'(param_index) < ptfig_pkg::STORE_DEPTH;
      end
      ptfig_pkg::CMD_VERTEX: begin
        cmd_in.op = ptfig_pkg::OP_VERTEX;
        keep      = 1'b1;
      end
      ptfig_pkg::CMD_FAN: begin
        cmd_in.op = ptfig_pkg::OP_FAN;
        keep      = int'(corner_count) >= MIN_CORNERS;
      end
      default: keep = 1'b0;
    endcase
  end

  // out-of-range writes, fans under three corners and unknown commands are taken and dropped here
  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o && keep;
  assign cmd_valid_o     = (cnt_q != 2'd0);
  assign pop             = cmd_valid_o && cmd_ready_i;
  assign cmd_o           = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd_in;
  end

  a_drop_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !keep) |=> (cnt_q <= $past(cnt_q)))
    else $error("dropped item entered the queue");

endmodule

/* design/ptfig_back.sv */
module ptfig_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  ptfig_pkg::cmd_t cmd_i,
  output logic            cmd_ready_o,
  output logic            res_valid_o,
  output ptfig_pkg::res_t res_o,
  input  logic            res_ready_i
);

  ptfig_pkg::state_e state_q, state_d;
  logic [ptfig_pkg::STEP_W-1:0]  step_q, step_d;
  logic [ptfig_pkg::LAYER_W-1:0] layer_q, layer_d;
  logic [ptfig_pkg::CNT_W-1:0]   k_q, k_d;

  ptfig_pkg::cmd_t item_q;
  logic [ptfig_pkg::NUM_LAYERS-1:0]      mask_q;
  logic [(1 << ptfig_pkg::LAYER_W)-1:0]  mask_ext;

  logic [31:0]                  store [ptfig_pkg::STORE_DEPTH];
  logic [ptfig_pkg::STORE_DEPTH-1:0] vld_q;
  logic [ptfig_pkg::ADDR_W-1:0] raddr;
  logic signed [31:0]           rdata_q;
  logic                         st_we;

  logic signed [32:0]                  mul_a;
  logic signed [ptfig_pkg::PROD_W-1:0] prod_d, prod_q;
  logic                                prod_en;
  logic signed [ptfig_pkg::FL_W-1:0]   fl;
  logic signed [ptfig_pkg::ACC_W-1:0]  acc_q;
  logic signed [31:0]                  cu_q, cv_q, ru_q, rv_d;
  logic signed [32:0]                  d_q;

  ptfig_pkg::lsel_t first_sel, nxt_sel;
  logic             out_free, out_load, fan_last, pop;
  ptfig_pkg::res_t  res_d, res_q;
  logic             res_valid_q;

  assign pop       = cmd_valid_i && cmd_ready_o;
  assign st_we     = pop && (cmd_i.op == ptfig_pkg::OP_WRITE);
  assign out_free  = !res_valid_q || res_ready_i;
  assign first_sel = ptfig_pkg::next_layer(mask_q, '0);
  assign nxt_sel   = ptfig_pkg::next_layer(mask_q,
                       (ptfig_pkg::LAYER_W + 1)'(layer_q) + (ptfig_pkg::LAYER_W + 1)'(1));
  assign fan_last  = ((ptfig_pkg::CNT_W + 1)'(k_q) + (ptfig_pkg::CNT_W + 1)'(2))
                     == (ptfig_pkg::CNT_W + 1)'(item_q.count);
  assign mask_ext  = (1 << ptfig_pkg::LAYER_W)'(mask_q);

  assign fl     = prod_q[ptfig_pkg::PROD_W-1:ptfig_pkg::FRAC];
  assign prod_d = ptfig_pkg::PROD_W'(mul_a) * ptfig_pkg::PROD_W'(rdata_q);
  assign rv_d   = ptfig_pkg::sat32(ptfig_pkg::SAT_W'(fl) + ptfig_pkg::SAT_W'(rdata_q));

  // multiplier operand and enable
  always_comb begin
    mul_a   = d_q;
    prod_en = 1'b0;
    case (state_q)
      ptfig_pkg::ST_PROJ: begin
        case (step_q)
          ptfig_pkg::P_MX_U, ptfig_pkg::P_MX_V: begin
            mul_a   = 33'(item_q.pos_x);
            prod_en = 1'b1;
          end
          ptfig_pkg::P_MY_U, ptfig_pkg::P_MY_V: begin
            mul_a   = 33'(item_q.pos_y);
            prod_en = 1'b1;
          end
          ptfig_pkg::P_MZ_U, ptfig_pkg::P_MZ_V: begin
            mul_a   = 33'(item_q.pos_z);
            prod_en = 1'b1;
          end
          default: prod_en = 1'b0;
        endcase
      end
      ptfig_pkg::ST_LAYER: begin
        prod_en = (step_q == ptfig_pkg::L_SCL_U) || (step_q == ptfig_pkg::L_SCL_V);
      end
      default: prod_en = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    layer_d     = layer_q;
    k_d         = k_q;
    cmd_ready_o = 1'b0;
    out_load    = 1'b0;
    res_d       = '0;
    case (state_q)
      ptfig_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            ptfig_pkg::OP_VERTEX: begin
              if (mask_q != '0) begin
                state_d = ptfig_pkg::ST_PROJ;
                step_d  = ptfig_pkg::P_MX_U;
              end
            end
            ptfig_pkg::OP_FAN: begin
              state_d = ptfig_pkg::ST_FAN;
              k_d     = ptfig_pkg::CNT_W'(1);
            end
            default: ;
          endcase
        end
      end
      ptfig_pkg::ST_PROJ: begin
        if (step_q == ptfig_pkg::P_OFF_V) begin
          state_d = ptfig_pkg::ST_LAYER;
          step_d  = ptfig_pkg::L_PAN_U;
          layer_d = first_sel.idx;
        end else begin
          step_d = step_q + ptfig_pkg::STEP_W'(1);
        end
      end
      ptfig_pkg::ST_LAYER: begin
        if (step_q == ptfig_pkg::L_OFS_V) begin
          // hold here until the output slot frees up
          if (out_free) begin
            out_load    = 1'b1;
            res_d.kind  = ptfig_pkg::KIND_PAIR;
            res_d.layer = layer_q;
            res_d.tex_u = ru_q;
            res_d.tex_v = rv_d;
            res_d.last  = !nxt_sel.found;
            if (nxt_sel.found) begin
              layer_d = nxt_sel.idx;
              step_d  = ptfig_pkg::L_PAN_U;
            end else begin
              state_d = ptfig_pkg::ST_IDLE;
            end
          end
        end else begin
          step_d = step_q + ptfig_pkg::STEP_W'(1);
        end
      end
      ptfig_pkg::ST_FAN: begin
        if (out_free) begin
          out_load       = 1'b1;
          res_d.kind     = ptfig_pkg::KIND_TRI;
          res_d.corner_a = item_q.first;
          res_d.corner_b = item_q.first + 24'(k_q);
          res_d.corner_c = item_q.first + 24'(k_q) + 24'd1;
          res_d.last     = fan_last;
          if (fan_last) begin
            state_d = ptfig_pkg::ST_IDLE;
          end else begin
            k_d = k_q + ptfig_pkg::CNT_W'(1);
          end
        end
      end
      default: state_d = ptfig_pkg::ST_IDLE;
    endcase
  end

  // read address follows the next step so the word is ready when the step runs
  always_comb begin
    case (state_d)
      ptfig_pkg::ST_PROJ:  raddr = ptfig_pkg::proj_addr(step_d);
      ptfig_pkg::ST_LAYER: raddr = ptfig_pkg::layer_addr(layer_d, step_d);
      default:             raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptfig_pkg::ST_IDLE;
      step_q      <= '0;
      layer_q     <= '0;
      k_q         <= '0;
      mask_q      <= '0;
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      layer_q <= layer_d;
      k_q     <= k_d;
      if (st_we) begin
        vld_q[cmd_i.addr] <= 1'b1;
        if (cmd_i.addr == ptfig_pkg::ADDR_W'(ptfig_pkg::MASK_ADDR)) begin
          mask_q <= cmd_i.value[ptfig_pkg::NUM_LAYERS-1:0];
        end
      end
      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // parameter store, unwritten words read as zero
  always_ff @(posedge clk_i) begin
    if (st_we) store[cmd_i.addr] <= cmd_i.value;
    rdata_q <= vld_q[raddr] ? store[raddr] : 32'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (pop) item_q <= cmd_i;
    if (prod_en) prod_q <= prod_d;
    if (out_load) res_q <= res_d;
    case (state_q)
      ptfig_pkg::ST_PROJ: begin
        case (step_q)
          ptfig_pkg::P_MY_U, ptfig_pkg::P_MY_V: acc_q <= ptfig_pkg::ACC_W'(fl);
          ptfig_pkg::P_MZ_U, ptfig_pkg::P_ACC_U,
          ptfig_pkg::P_MZ_V, ptfig_pkg::P_ACC_V: acc_q <= acc_q + ptfig_pkg::ACC_W'(fl);
          ptfig_pkg::P_OFF_U: cu_q <= ptfig_pkg::sat32(ptfig_pkg::SAT_W'(acc_q)
                                                       - ptfig_pkg::SAT_W'(rdata_q));
          ptfig_pkg::P_OFF_V: cv_q <= ptfig_pkg::sat32(ptfig_pkg::SAT_W'(acc_q)
                                                       - ptfig_pkg::SAT_W'(rdata_q));
          default: ;
        endcase
      end
      ptfig_pkg::ST_LAYER: begin
        case (step_q)
          ptfig_pkg::L_PAN_U: d_q  <= 33'(cu_q) - 33'(rdata_q);
          ptfig_pkg::L_OFS_U: ru_q <= rv_d;
          ptfig_pkg::L_PAN_V: d_q  <= 33'(cv_q) - 33'(rdata_q);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_layer_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptfig_pkg::ST_LAYER) |-> mask_ext[layer_q])
    else $error("processing a disabled layer");

  a_fan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptfig_pkg::ST_FAN) |->
      ((ptfig_pkg::CNT_W + 1)'(k_q) + (ptfig_pkg::CNT_W + 1)'(2)
       <= (ptfig_pkg::CNT_W + 1)'(item_q.count)))
    else $error("fan index ran past the corner count");

  a_tri_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.kind == ptfig_pkg::KIND_TRI) |->
      (res_q.corner_c == res_q.corner_b + 24'd1))
    else $error("triangle corners not adjacent");

endmodule

/* design/planar_texcoord_and_fan_index_gen_unit.sv */
// Planar texture coordinate and triangle-fan index generator. Input items are
// parameter writes, vertices and polygons; a two-entry queue decouples intake
// from the sequencer. A vertex is first projected onto both axes, then
// processed once per enabled layer, each layer ending in one u,v result; the
// single shared 33x32 multiplier and the one read port of the 39-word
// parameter store make these steps run one after another. A polygon gives one
// triangle (first, first+k, first+k+1) per cycle while the output is not
// stalled.
module planar_texcoord_and_fan_index_gen_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // param_index, param_value, pos_x, pos_y, pos_z, first_vertex, corner_count, zero pad
  input  logic [ptfig_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // command
  input  logic [ptfig_pkg::IN_TUSER_W-1:0]      s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // layer, tex_u, tex_v, corner_a, corner_b, corner_c, zero pad
  output logic [ptfig_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // kind
  output logic                                  m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);

  logic            cmd_valid, cmd_ready;
  ptfig_pkg::cmd_t cmd;
  ptfig_pkg::res_t res;

  ptfig_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_ready_i     (cmd_ready)
  );

  ptfig_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {5'd0, res.corner_c, res.corner_b, res.corner_a,
                           res.tex_v, res.tex_u, res.layer};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule
